### src/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin task scheduler core.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int MAX_TASK_SLOTS = 16;
    localparam int SLOT_W = (MAX_TASK_SLOTS > 1) ? $clog2(MAX_TASK_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASK_SLOTS + 1);

    typedef enum logic [2:0] {
        MODE_CREATE = 3'd0,
        MODE_START  = 3'd1,
        MODE_PICK   = 3'd2,
        MODE_SLEEP  = 3'd3,
        MODE_EXIT   = 3'd4,
        MODE_TICK   = 3'd5,
        MODE_QUERY  = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ST_RUNNABLE = 2'd0,
        ST_SLEEPING = 2'd1,
        ST_DONE     = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        status_t           wr_status;
        logic              wr_wake_en;
        logic [31:0]       wr_wake;
        logic [SLOT_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [3:0]  current_task;
        logic        has_current;
        logic [3:0]  created_id;
        logic        create_failed;
        logic [4:0]  task_total;
        logic [31:0] tick_count;
        logic [1:0]  queried_state;
        logic        switch_request;
    } res_word_t;

endpackage

### src/rrts_evt_if.sv
// ----------------------------------------------------------------------------
// rrts_evt_if
// Event channel: one scheduler event word per handshake.
// ----------------------------------------------------------------------------
interface rrts_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] sleep_ticks;
    logic [3:0]  query_index;

    modport source (output valid, output mode, output sleep_ticks, output query_index,
                    input ready);
    modport sink   (input valid, input mode, input sleep_ticks, input query_index,
                    output ready);
endinterface

### src/rrts_res_if.sv
// ----------------------------------------------------------------------------
// rrts_res_if
// Result channel: one scheduler status word per handshake.
// ----------------------------------------------------------------------------
interface rrts_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  current_task;
    logic        has_current;
    logic [3:0]  created_id;
    logic        create_failed;
    logic [4:0]  task_total;
    logic [31:0] tick_count;
    logic [1:0]  queried_state;
    logic        switch_request;

    modport source (output valid, output current_task, output has_current,
                    output created_id, output create_failed, output task_total,
                    output tick_count, output queried_state, output switch_request,
                    input ready);
    modport sink   (input valid, input current_task, input has_current,
                    input created_id, input create_failed, input task_total,
                    input tick_count, input queried_state, input switch_request,
                    output ready);
endinterface

### src/rrts_table.sv
// ----------------------------------------------------------------------------
// rrts_table
// Task table: status and wake time per slot, one write and one registered read.
// ----------------------------------------------------------------------------
module rrts_table
(
    input  logic                clk,
    input  rrts_pkg::mem_req_t  req,
    output rrts_pkg::status_t   rd_status,
    output logic [31:0]         rd_wake
);

    rrts_pkg::status_t status_mem [rrts_pkg::MAX_TASK_SLOTS];
    logic [31:0]       wake_mem   [rrts_pkg::MAX_TASK_SLOTS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            status_mem[req.wr_addr] <= req.wr_status;
        end
        if (req.wr_wake_en)
        begin
            wake_mem[req.wr_addr] <= req.wr_wake;
        end
        rd_status <= status_mem[req.rd_addr];
        rd_wake   <= wake_mem[req.rd_addr];
    end

endmodule

### src/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// Event sequencer: scheduler state, slot walk for tick and pick, result build.
// ----------------------------------------------------------------------------
module rrts_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    rrts_evt_if.sink              evt,
    output rrts_pkg::mem_req_t    req,
    input  rrts_pkg::status_t     rd_status,
    input  logic [31:0]           rd_wake,
    output rrts_pkg::res_word_t   res_word,
    output logic                  res_load,
    input  logic                  res_free
);

    localparam int SW = rrts_pkg::SLOT_W;
    localparam int CW = rrts_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_QUERY,
        S_DONE
    } state_t;

    state_t              state_reg,   state_next;
    rrts_pkg::mode_t     mode_reg,    mode_next;
    logic [CW-1:0]       count_reg,   count_next;
    logic [31:0]         tick_reg,    tick_next;
    logic [SW-1:0]       cur_reg,     cur_next;
    logic                cur_v_reg,   cur_v_next;
    logic [SW-1:0]       base_reg,    base_next;
    logic [SW-1:0]       iss_ptr_reg, iss_ptr_next;
    logic [CW-1:0]       iss_cnt_reg, iss_cnt_next;
    logic                chk_v_reg,   chk_v_next;
    logic [SW-1:0]       chk_ptr_reg, chk_ptr_next;
    logic                chk_last_reg, chk_last_next;
    logic [3:0]          cid_reg,     cid_next;
    logic                fail_reg,    fail_next;
    logic [1:0]          qst_reg,     qst_next;
    logic                sw_reg,      sw_next;

    logic [CW+3:0]       q_ext;
    logic [CW+3:0]       n_ext;
    logic                accept;

    function automatic logic [SW-1:0] wrap_next(input logic [SW-1:0] p,
                                                input logic [CW-1:0] n);
        logic [CW-1:0] q;
        q = CW'(p) + 1'b1;
        return (q == n) ? '0 : q[SW-1:0];
    endfunction

    assign evt.ready = (state_reg == S_IDLE);
    assign accept    = evt.valid && evt.ready;
    assign q_ext     = {{CW{1'b0}}, evt.query_index};
    assign n_ext     = {4'd0, count_reg};
    assign res_load  = (state_reg == S_DONE) && res_free;

    always_comb
    begin
        res_word.current_task   = 4'(cur_reg);
        res_word.has_current    = cur_v_reg;
        res_word.created_id     = cid_reg;
        res_word.create_failed  = fail_reg;
        res_word.task_total     = 5'(count_reg);
        res_word.tick_count     = tick_reg;
        res_word.queried_state  = qst_reg;
        res_word.switch_request = sw_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        count_next    = count_reg;
        tick_next     = tick_reg;
        cur_next      = cur_reg;
        cur_v_next    = cur_v_reg;
        base_next     = base_reg;
        iss_ptr_next  = iss_ptr_reg;
        iss_cnt_next  = iss_cnt_reg;
        chk_v_next    = 1'b0;
        chk_ptr_next  = chk_ptr_reg;
        chk_last_next = chk_last_reg;
        cid_next      = cid_reg;
        fail_next     = fail_reg;
        qst_next      = qst_reg;
        sw_next       = sw_reg;

        req.wr_en      = 1'b0;
        req.wr_addr    = cur_reg;
        req.wr_status  = rrts_pkg::ST_RUNNABLE;
        req.wr_wake_en = 1'b0;
        req.wr_wake    = '0;
        req.rd_addr    = iss_ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = rrts_pkg::mode_t'(evt.mode);
                    cid_next   = '0;
                    fail_next  = 1'b0;
                    qst_next   = '0;
                    sw_next    = 1'b0;
                    state_next = S_DONE;
                    case (rrts_pkg::mode_t'(evt.mode))
                        rrts_pkg::MODE_CREATE:
                        begin
                            if (count_reg >= CW'(rrts_pkg::MAX_TASK_SLOTS))
                            begin
                                fail_next = 1'b1;
                            end
                            else
                            begin
                                req.wr_en      = 1'b1;
                                req.wr_addr    = count_reg[SW-1:0];
                                req.wr_status  = rrts_pkg::ST_RUNNABLE;
                                req.wr_wake_en = 1'b1;
                                req.wr_wake    = '0;
                                cid_next       = 4'(count_reg);
                                count_next     = count_reg + 1'b1;
                            end
                        end
                        rrts_pkg::MODE_START:
                        begin
                            cur_next   = '0;
                            cur_v_next = (count_reg != '0);
                        end
                        rrts_pkg::MODE_PICK:
                        begin
                            if (count_reg == '0)
                            begin
                                cur_next   = '0;
                                cur_v_next = 1'b0;
                            end
                            else
                            begin
                                if (cur_v_reg && (CW'(cur_reg) < count_reg))
                                begin
                                    base_next    = cur_reg;
                                    iss_ptr_next = wrap_next(cur_reg, count_reg);
                                end
                                else
                                begin
                                    base_next    = '0;
                                    iss_ptr_next = wrap_next('0, count_reg);
                                end
                                iss_cnt_next = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        rrts_pkg::MODE_SLEEP:
                        begin
                            if (cur_v_reg)
                            begin
                                sw_next = 1'b1;
                                if (evt.sleep_ticks != '0)
                                begin
                                    req.wr_en      = 1'b1;
                                    req.wr_addr    = cur_reg;
                                    req.wr_status  = rrts_pkg::ST_SLEEPING;
                                    req.wr_wake_en = 1'b1;
                                    req.wr_wake    = tick_reg + evt.sleep_ticks;
                                end
                            end
                        end
                        rrts_pkg::MODE_EXIT:
                        begin
                            if (cur_v_reg)
                            begin
                                sw_next       = 1'b1;
                                req.wr_en     = 1'b1;
                                req.wr_addr   = cur_reg;
                                req.wr_status = rrts_pkg::ST_DONE;
                            end
                        end
                        rrts_pkg::MODE_TICK:
                        begin
                            tick_next = tick_reg + 1'b1;
                            if (count_reg != '0)
                            begin
                                iss_ptr_next = '0;
                                iss_cnt_next = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        rrts_pkg::MODE_QUERY:
                        begin
                            if (q_ext < n_ext)
                            begin
                                req.rd_addr = q_ext[SW-1:0];
                                state_next  = S_QUERY;
                            end
                            else
                            begin
                                qst_next = rrts_pkg::ST_NONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // issue one slot read per cycle, check the slot read last cycle
                if (iss_cnt_reg < count_reg)
                begin
                    req.rd_addr   = iss_ptr_reg;
                    chk_v_next    = 1'b1;
                    chk_ptr_next  = iss_ptr_reg;
                    chk_last_next = (CW'(iss_cnt_reg + 1'b1) == count_reg);
                    iss_cnt_next  = iss_cnt_reg + 1'b1;
                    iss_ptr_next  = wrap_next(iss_ptr_reg, count_reg);
                end
                if (chk_v_reg)
                begin
                    if (mode_reg == rrts_pkg::MODE_PICK)
                    begin
                        if (rd_status == rrts_pkg::ST_RUNNABLE)
                        begin
                            cur_next   = chk_ptr_reg;
                            cur_v_next = 1'b1;
                            chk_v_next = 1'b0;
                            state_next = S_DONE;
                        end
                        else if (chk_last_reg)
                        begin
                            cur_next   = base_reg;
                            cur_v_next = 1'b1;
                            chk_v_next = 1'b0;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        if ((rd_status == rrts_pkg::ST_SLEEPING) && (tick_reg >= rd_wake))
                        begin
                            req.wr_en     = 1'b1;
                            req.wr_addr   = chk_ptr_reg;
                            req.wr_status = rrts_pkg::ST_RUNNABLE;
                        end
                        if (chk_last_reg)
                        begin
                            chk_v_next = 1'b0;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_QUERY:
            begin
                qst_next   = rd_status;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= rrts_pkg::MODE_CREATE;
            count_reg    <= '0;
            tick_reg     <= '0;
            cur_reg      <= '0;
            cur_v_reg    <= 1'b0;
            base_reg     <= '0;
            iss_ptr_reg  <= '0;
            iss_cnt_reg  <= '0;
            chk_v_reg    <= 1'b0;
            chk_ptr_reg  <= '0;
            chk_last_reg <= 1'b0;
            cid_reg      <= '0;
            fail_reg     <= 1'b0;
            qst_reg      <= '0;
            sw_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            tick_reg     <= tick_next;
            cur_reg      <= cur_next;
            cur_v_reg    <= cur_v_next;
            base_reg     <= base_next;
            iss_ptr_reg  <= iss_ptr_next;
            iss_cnt_reg  <= iss_cnt_next;
            chk_v_reg    <= chk_v_next;
            chk_ptr_reg  <= chk_ptr_next;
            chk_last_reg <= chk_last_next;
            cid_reg      <= cid_next;
            fail_reg     <= fail_next;
            qst_reg      <= qst_next;
            sw_reg       <= sw_next;
        end
    end

endmodule

### src/round_robin_task_scheduler_core.sv
// Create, start, sleep, exit and unused modes pass from acceptance through the done
// state to the result register; query also passes a table read state, and tick and pick
// walk the task table one slot per cycle (tick over all n tasks created, pick up to n).
// The next event is taken once the previous word is loaded into the result register,
// so the block takes no new event while one is in work; a stalled word holds it longer.
// Reset clears the task count, tick counter and selection; the table is not cleared.
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_core
// Round-robin task scheduler with sleep timers: sequencer, task table, result register.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core
(
    input  logic        clk,
    input  logic        rst_n,
    rrts_evt_if.sink    evt,
    rrts_res_if.source  res
);

    rrts_pkg::mem_req_t  req;
    rrts_pkg::status_t   rd_status;
    logic [31:0]         rd_wake;
    rrts_pkg::res_word_t res_word;
    logic                res_load;
    logic                res_free;

    logic                res_valid_reg;
    rrts_pkg::res_word_t res_word_reg;

    rrts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .req       (req),
        .rd_status (rd_status),
        .rd_wake   (rd_wake),
        .res_word  (res_word),
        .res_load  (res_load),
        .res_free  (res_free)
    );

    rrts_table u_table
    (
        .clk       (clk),
        .req       (req),
        .rd_status (rd_status),
        .rd_wake   (rd_wake)
    );

    assign res_free = !res_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_word_reg <= res_word;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.current_task   = res_word_reg.current_task;
    assign res.has_current    = res_word_reg.has_current;
    assign res.created_id     = res_word_reg.created_id;
    assign res.create_failed  = res_word_reg.create_failed;
    assign res.task_total     = res_word_reg.task_total;
    assign res.tick_count     = res_word_reg.tick_count;
    assign res.queried_state  = res_word_reg.queried_state;
    assign res.switch_request = res_word_reg.switch_request;

endmodule

### dv/round_robin_task_scheduler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_core_tb
// Drives scheduler events through the event channel with bursty pacing and
// checks status words against a cycle-free scheduler model kept here.
// A short stimulus table covers empty-table cases, wraparound sleep, a full
// table and unused mode; random event streams over a full table follow.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core_tb;

    localparam logic [2:0] MODE_NOP     = 3'd7;
    localparam int         RANDOM_WORDS = 1300;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         TAIL_CYCLES  = 40;
    localparam int         PLAN_ROWS    = 25;

    typedef struct packed {
        logic [2:0]          mode;
        logic [31:0]         ticks;
        logic [3:0]          qidx;
        int                  reps;
        bit                  typed;
        rrts_pkg::res_word_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic ready_q = 1'b0;

    rrts_evt_if evt_ch ();
    rrts_res_if res_ch ();

    assign res_ch.ready = ready_q;

    round_robin_task_scheduler_core uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch)
    );

    always #1 clk = ~clk;

    // scheduler model state
    rrts_pkg::status_t slot_status [rrts_pkg::MAX_TASK_SLOTS];
    logic [31:0]       slot_wake [rrts_pkg::MAX_TASK_SLOTS];
    logic [4:0]        made_count = '0;
    logic [31:0]       tick_now = '0;
    logic [3:0]        sel_index = '0;
    logic              sel_valid = 1'b0;

    rrts_pkg::res_word_t pending_words [$];
    rrts_pkg::res_word_t seen_word;
    rrts_pkg::res_word_t oldest_word;
    int                  mismatches = 0;
    int                  cycle_count = 0;
    int                  burst_left = 0;
    logic [15:0]         ready_pattern = 16'hFFFF;
    int                  pattern_age = 0;

    stim_row_t plan [PLAN_ROWS] = '{
        '{rrts_pkg::MODE_QUERY,  32'd0,          4'd0,  1,  1'b1,
          {4'd0, 1'b0, 4'd0, 1'b0, 5'd0,  32'd0, rrts_pkg::ST_NONE, 1'b0}},
        '{rrts_pkg::MODE_SLEEP,  32'hFFFF_FFFF,  4'd0,  1,  1'b1,
          {4'd0, 1'b0, 4'd0, 1'b0, 5'd0,  32'd0, 2'd0, 1'b0}},
        '{rrts_pkg::MODE_EXIT,   32'd0,          4'd0,  1,  1'b1,
          {4'd0, 1'b0, 4'd0, 1'b0, 5'd0,  32'd0, 2'd0, 1'b0}},
        '{rrts_pkg::MODE_PICK,   32'd0,          4'd0,  1,  1'b1,
          {4'd0, 1'b0, 4'd0, 1'b0, 5'd0,  32'd0, 2'd0, 1'b0}},
        '{rrts_pkg::MODE_START,  32'd0,          4'd0,  1,  1'b1,
          {4'd0, 1'b0, 4'd0, 1'b0, 5'd0,  32'd0, 2'd0, 1'b0}},
        '{rrts_pkg::MODE_TICK,   32'd0,          4'd0,  1,  1'b1,
          {4'd0, 1'b0, 4'd0, 1'b0, 5'd0,  32'd1, 2'd0, 1'b0}},
        '{MODE_NOP,              32'd0,          4'd0,  1,  1'b1,
          {4'd0, 1'b0, 4'd0, 1'b0, 5'd0,  32'd1, 2'd0, 1'b0}},
        '{rrts_pkg::MODE_CREATE, 32'd0,          4'd0,  1,  1'b1,
          {4'd0, 1'b0, 4'd0, 1'b0, 5'd1,  32'd1, 2'd0, 1'b0}},
        '{rrts_pkg::MODE_QUERY,  32'd0,          4'd1,  1,  1'b1,
          {4'd0, 1'b0, 4'd0, 1'b0, 5'd1,  32'd1, rrts_pkg::ST_NONE, 1'b0}},
        '{rrts_pkg::MODE_START,  32'd0,          4'd0,  1,  1'b1,
          {4'd0, 1'b1, 4'd0, 1'b0, 5'd1,  32'd1, 2'd0, 1'b0}},
        '{rrts_pkg::MODE_SLEEP,  32'd0,          4'd0,  1,  1'b1,
          {4'd0, 1'b1, 4'd0, 1'b0, 5'd1,  32'd1, 2'd0, 1'b1}},
        '{rrts_pkg::MODE_PICK,   32'd0,          4'd0,  1,  1'b0, '0},
        '{rrts_pkg::MODE_SLEEP,  32'hFFFF_FFFF,  4'd0,  1,  1'b0, '0},
        '{rrts_pkg::MODE_PICK,   32'd0,          4'd0,  1,  1'b0, '0},
        '{rrts_pkg::MODE_QUERY,  32'd0,          4'd0,  1,  1'b0, '0},
        '{rrts_pkg::MODE_TICK,   32'd0,          4'd0,  1,  1'b0, '0},
        '{rrts_pkg::MODE_CREATE, 32'd0,          4'd0,  15, 1'b0, '0},
        '{rrts_pkg::MODE_CREATE, 32'd0,          4'd0,  1,  1'b1,
          {4'd0, 1'b1, 4'd0, 1'b1, 5'd16, 32'd2, 2'd0, 1'b0}},
        '{rrts_pkg::MODE_QUERY,  32'd0,          4'd15, 1,  1'b0, '0},
        '{rrts_pkg::MODE_SLEEP,  32'd1,          4'd0,  1,  1'b0, '0},
        '{rrts_pkg::MODE_PICK,   32'd0,          4'd0,  1,  1'b0, '0},
        '{rrts_pkg::MODE_EXIT,   32'd0,          4'd0,  1,  1'b0, '0},
        '{rrts_pkg::MODE_TICK,   32'd0,          4'd0,  1,  1'b0, '0},
        '{rrts_pkg::MODE_PICK,   32'd0,          4'd0,  1,  1'b0, '0},
        '{MODE_NOP,              32'hFFFF_FFFF,  4'd15, 1,  1'b0, '0}
    };

    assign seen_word = {res_ch.current_task, res_ch.has_current, res_ch.created_id,
                        res_ch.create_failed, res_ch.task_total, res_ch.tick_count,
                        res_ch.queried_state, res_ch.switch_request};

    function automatic rrts_pkg::res_word_t schedule_event(input logic [2:0] m,
                                                           input logic [31:0] t,
                                                           input logic [3:0] q);
        rrts_pkg::res_word_t word;
        int                  n;
        int                  cur;
        int                  slot;
        bit                  found;
        word = '0;
        case (m)
            rrts_pkg::MODE_CREATE:
            begin
                if (made_count >= rrts_pkg::MAX_TASK_SLOTS)
                begin
                    word.create_failed = 1'b1;
                end
                else
                begin
                    slot_status[made_count[3:0]] = rrts_pkg::ST_RUNNABLE;
                    slot_wake[made_count[3:0]]   = '0;
                    word.created_id              = made_count[3:0];
                    made_count                   = made_count + 5'd1;
                end
            end
            rrts_pkg::MODE_START:
            begin
                sel_index = '0;
                sel_valid = (made_count != 0);
            end
            rrts_pkg::MODE_PICK:
            begin
                n = made_count;
                if (n == 0)
                begin
                    sel_valid = 1'b0;
                    sel_index = '0;
                end
                else
                begin
                    cur   = sel_valid ? int'(sel_index) : 0;
                    found = 1'b0;
                    if (cur >= n)
                        cur = 0;
                    for (int k = 1; k <= n && !found; k++)
                    begin
                        slot = (cur + k) % n;
                        if (slot_status[slot] == rrts_pkg::ST_RUNNABLE)
                        begin
                            sel_index = slot[3:0];
                            found     = 1'b1;
                        end
                    end
                    if (!found)
                        sel_index = cur[3:0];
                    sel_valid = 1'b1;
                end
            end
            rrts_pkg::MODE_SLEEP:
            begin
                if (sel_valid)
                begin
                    if (t != 0)
                    begin
                        slot_status[sel_index] = rrts_pkg::ST_SLEEPING;
                        slot_wake[sel_index]   = tick_now + t;
                    end
                    word.switch_request = 1'b1;
                end
            end
            rrts_pkg::MODE_EXIT:
            begin
                if (sel_valid)
                begin
                    slot_status[sel_index] = rrts_pkg::ST_DONE;
                    word.switch_request    = 1'b1;
                end
            end
            rrts_pkg::MODE_TICK:
            begin
                tick_now = tick_now + 32'd1;
                for (int i = 0; i < made_count; i++)
                begin
                    if (slot_status[i] == rrts_pkg::ST_SLEEPING && tick_now >= slot_wake[i])
                        slot_status[i] = rrts_pkg::ST_RUNNABLE;
                end
            end
            rrts_pkg::MODE_QUERY:
            begin
                word.queried_state = (q < made_count) ? slot_status[q] : rrts_pkg::ST_NONE;
            end
            default:
            begin
            end
        endcase
        word.current_task = sel_index;
        word.has_current  = sel_valid;
        word.task_total   = made_count;
        word.tick_count   = tick_now;
        return word;
    endfunction

    function automatic string word_text(input rrts_pkg::res_word_t w);
        return $sformatf("cur=%0d has=%0b id=%0d fail=%0b total=%0d tick=%0h q=%0d sw=%0b",
                         w.current_task, w.has_current, w.created_id, w.create_failed,
                         w.task_total, w.tick_count, w.queried_state, w.switch_request);
    endfunction

    task automatic send_event(input logic [2:0] m, input logic [31:0] t, input logic [3:0] q,
                              input bit typed, input rrts_pkg::res_word_t want);
        rrts_pkg::res_word_t model_word;
        @(negedge clk);
        evt_ch.valid       <= 1'b1;
        evt_ch.mode        <= m;
        evt_ch.sleep_ticks <= t;
        evt_ch.query_index <= q;
        do
            @(posedge clk);
        while (!evt_ch.ready);
        model_word = schedule_event(m, t, q);
        pending_words.push_back(typed ? want : model_word);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                evt_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic drain_results();
        @(negedge clk);
        evt_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (pattern_age == 0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pattern <= 16'hFFFF;
                1:       ready_pattern <= 16'h00FF;
                2:       ready_pattern <= 16'h0101;
                default: ready_pattern <= 16'($urandom) | 16'h8000;
            endcase
            pattern_age <= $urandom_range(20, 80);
        end
        else
        begin
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
            pattern_age   <= pattern_age - 1;
        end
        ready_q <= ready_pattern[15];
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && ready_q)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word, expected none, got %s", $time,
                         word_text(seen_word));
            end
            else
            begin
                oldest_word = pending_words.pop_front();
                if (seen_word !== oldest_word)
                begin
                    mismatches++;
                    $display("%0t: expected %s", $time, word_text(oldest_word));
                    $display("%0t: got      %s", $time, word_text(seen_word));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("round_robin_task_scheduler_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        int          pick;
        logic [2:0]  m;
        logic [31:0] t;
        logic [3:0]  q;
        evt_ch.valid       = 1'b0;
        evt_ch.mode        = '0;
        evt_ch.sleep_ticks = '0;
        evt_ch.query_index = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            repeat (plan[r].reps)
            begin
                pace_sender();
                send_event(plan[r].mode, plan[r].ticks, plan[r].qidx, plan[r].typed,
                           plan[r].want);
            end
        end
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            t    = $urandom;
            q    = 4'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 25)
                m = rrts_pkg::MODE_PICK;
            else if (pick < 50)
                m = rrts_pkg::MODE_TICK;
            else if (pick < 70)
            begin
                m = rrts_pkg::MODE_SLEEP;
                case ($urandom_range(0, 19))
                    0:       t = '0;
                    1:       t = $urandom;
                    default: t = $urandom_range(1, 12);
                endcase
            end
            else if (pick < 71)
                m = rrts_pkg::MODE_EXIT;
            else if (pick < 77)
                m = rrts_pkg::MODE_START;
            else if (pick < 91)
                m = rrts_pkg::MODE_QUERY;
            else if (pick < 96)
                m = rrts_pkg::MODE_CREATE;
            else
                m = MODE_NOP;
            pace_sender();
            send_event(m, t, q, 1'b0, '0);
            if (n % 300 == 299)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("round_robin_task_scheduler_core: match");
        else
            $display("round_robin_task_scheduler_core: mismatch");
        $finish;
    end

endmodule

### files.f
src/rrts_pkg.sv
src/rrts_evt_if.sv
src/rrts_res_if.sv
src/rrts_table.sv
src/rrts_ctrl.sv
src/round_robin_task_scheduler_core.sv
dv/round_robin_task_scheduler_core_tb.sv
